// ----- rtl/amr_pkg.sv -----
// ============================================================================
// amr_pkg: shared types and constants of the aging message ring
// Holds the word formats of both channels, the command format of the
// queue between front and back, and the register map.
// ============================================================================
package amr_pkg;

  localparam int AREA_W     = 4;
  localparam int LIFE_W     = 14;
  localparam int HANDLE_W   = 16;
  localparam int ELAPSED_W  = 10;
  localparam int LINE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  // At most this many lines are scanned by one tick.
  localparam int RESULT_CAP = 8;

  localparam logic [AREA_W-1:0] DEFAULT_AREA     = 4'd4;
  localparam logic [LIFE_W-1:0] DEFAULT_LIFETIME = 14'd4000;
  localparam logic [LIFE_W-1:0] LIFETIME_MIN     = 14'd100;
  localparam logic [LIFE_W-1:0] LIFETIME_MAX     = 14'd10000;

  // Register map of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_AREA_SIZE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIFETIME = 1'b1;

  typedef enum logic {
    CMD_POST = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } bk_state_e;

  typedef struct packed {
    logic                 action;
    logic [HANDLE_W-1:0]  message_handle;
    logic [ELAPSED_W-1:0] elapsed_frames;
  } in_word_t;

  typedef struct packed {
    logic                line_valid;
    logic [HANDLE_W-1:0] shown_handle;
    logic [LINE_W-1:0]   line_index;
    logic                last_line;
  } out_word_t;

  typedef struct packed {
    cmd_e                 kind;
    logic [HANDLE_W-1:0]  handle;
    logic [ELAPSED_W-1:0] elapsed;
  } cmd_t;

  // Configuration seen by the ring engine.
  typedef struct packed {
    logic [AREA_W-1:0] area_size;
    logic [LIFE_W-1:0] lifetime;
    logic              clear;
  } ring_cfg_t;

endpackage

// ----- rtl/amr_front.sv -----
// ============================================================================
// amr_front: input side of the aging message ring
// Accepts words, classifies them into post or tick commands and holds them
// in a two-entry queue until the ring engine takes them.
// ============================================================================
module amr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  amr_pkg::in_word_t in_word_i,
  output logic             cmd_valid_o,
  output amr_pkg::cmd_t    cmd_o,
  input  logic             cmd_pop_i
);
  import amr_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              cmd_in;

  assign in_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_in.kind    = in_word_i.action ? CMD_TICK : CMD_POST;
    cmd_in.handle  = in_word_i.message_handle;
    cmd_in.elapsed = in_word_i.elapsed_frames;
  end

  always_comb begin
    wr_d  = push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/amr_back.sv -----
// ============================================================================
// amr_back: ring engine of the aging message ring
// Executes posts and walks a tick over the ring one slot per cycle, aging
// lifetimes and writing one word per slot to the output register when it is free.
// ============================================================================
module amr_back #(
  parameter int LIM = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  amr_pkg::ring_cfg_t cfg_i,
  input  logic               cmd_valid_i,
  input  amr_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output amr_pkg::out_word_t out_word_o
);
  import amr_pkg::*;

  localparam int PW = (LIM > 1) ? $clog2(LIM) : 1;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p,
                                              input logic [AREA_W-1:0] area);
    logic [AREA_W-1:0] n;
    n = AREA_W'(p) + AREA_W'(1);
    return (n >= area) ? '0 : PW'(n);
  endfunction

  bk_state_e state_q, state_d;

  logic [HANDLE_W-1:0]  handle_q [LIM];
  logic [LIFE_W-1:0]    life_q [LIM];
  logic [PW-1:0]        head_q, head_d;
  logic [PW-1:0]        tail_q, tail_d;
  logic                 empty_q, empty_d;
  logic [PW-1:0]        cur_q, cur_d;
  logic [LINE_W-1:0]    line_q, line_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_word_q, out_word_d;

  logic                 do_post, do_tick, do_step, slot_free, last_step;
  logic [PW-1:0]        post_slot;
  logic [LIFE_W-1:0]    cur_life, new_life;
  logic                 cur_live;
  logic                 life_we;
  logic [PW-1:0]        life_waddr;
  logic [LIFE_W-1:0]    life_wdata;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_step = (AREA_W'(line_q) + AREA_W'(1)) == cfg_i.area_size;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == CMD_TICK) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (slot_free && last_step) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd_pop_o = 1'b0;
    do_post   = 1'b0;
    do_tick   = 1'b0;
    do_step   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        do_post   = cmd_valid_i && cmd_i.kind == CMD_POST;
        do_tick   = cmd_valid_i && cmd_i.kind == CMD_TICK;
      end
      BK_SCAN: begin
        do_step = slot_free;
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  // Aging of the slot under the scan, saturating at zero.
  always_comb begin
    cur_life = life_q[cur_q];
    cur_live = (cur_life != '0);
    new_life = (LIFE_W'(elapsed_q) >= cur_life) ? '0 : cur_life - LIFE_W'(elapsed_q);
  end

  assign post_slot = empty_q ? '0 : next_slot(tail_q, cfg_i.area_size);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    cur_d       = cur_q;
    line_d      = line_q;
    elapsed_d   = elapsed_q;
    life_we     = 1'b0;
    life_waddr  = cur_q;
    life_wdata  = new_life;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (do_post) begin
      if (empty_q) begin
        head_d  = '0;
        empty_d = 1'b0;
      end else if (post_slot == head_q) begin
        // Full ring: the oldest entry is overwritten.
        head_d = next_slot(head_q, cfg_i.area_size);
      end
      tail_d     = post_slot;
      life_we    = 1'b1;
      life_waddr = post_slot;
      life_wdata = cfg_i.lifetime;
    end

    if (do_tick) begin
      cur_d     = head_q;
      line_d    = '0;
      elapsed_d = cmd_i.elapsed;
    end

    if (do_step) begin
      out_valid_d             = 1'b1;
      out_word_d.line_valid   = cur_live;
      out_word_d.shown_handle = cur_live ? handle_q[cur_q] : '0;
      out_word_d.line_index   = line_q;
      out_word_d.last_line    = last_step;
      life_we                 = cur_live;
      if (cur_live && new_life == '0 && !empty_q) begin
        if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else begin
          head_d = next_slot(head_q, cfg_i.area_size);
        end
      end
      cur_d  = next_slot(cur_q, cfg_i.area_size);
      line_d = line_q + LINE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.clear) begin
        head_q  <= '0;
        tail_q  <= '0;
        empty_q <= 1'b1;
      end else begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        empty_q <= empty_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIM; i++) begin
        life_q[i] <= '0;
      end
    end else if (cfg_i.clear) begin
      for (int i = 0; i < LIM; i++) begin
        life_q[i] <= '0;
      end
    end else if (life_we) begin
      life_q[life_waddr] <= life_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_post) begin
      handle_q[post_slot] <= cmd_i.handle;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    line_q     <= line_d;
    elapsed_q  <= elapsed_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/aging_message_ring_core.sv -----
// ============================================================================
// aging_message_ring_core: ring of timed message slots with a line scan
// A post appends a handle at the tail; a tick walks the ring from the head,
// reports one line per slot and ages each live slot's lifetime.
// ============================================================================
// Operation: an accepted command waits in the front queue; the engine pops a
// post and writes it into the ring, or pops a tick, loads the scan state and
// then writes one word per slot to the output register, one slot per cycle
// while that register is free. The engine takes no new command during a scan.
// Reset: the ring is empty, all lifetimes zero, area_size 4 (or MAX_LINES if
// smaller) and entry_lifetime 4000; the handle store is not cleared.
module aging_message_ring_core #(
  parameter int MAX_LINES = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  amr_pkg::in_word_t                      in_word_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output amr_pkg::out_word_t                     out_word_o,
  input  logic                                   cfg_we_i,
  input  logic [amr_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [amr_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import amr_pkg::*;

  // Only the first LIM slots can ever be reached by the pointers, since the
  // area is limited both by the slot count and by the lines one tick reports.
  localparam int LIM = (MAX_LINES < RESULT_CAP) ? MAX_LINES : RESULT_CAP;
  localparam logic [AREA_W-1:0] AREA_LIM  = AREA_W'(LIM);
  localparam logic [AREA_W-1:0] AREA_INIT =
    (DEFAULT_AREA <= AREA_LIM) ? DEFAULT_AREA : AREA_LIM;

  logic [AREA_W-1:0] area_q, area_d;
  logic [LIFE_W-1:0] lifetime_q, lifetime_d;
  logic              clear;
  logic [AREA_W-1:0] area_wr;
  ring_cfg_t         ring_cfg;
  logic              cmd_valid, cmd_pop;
  cmd_t              cmd;

  // Configuration decode. Any area write clears the ring; an area value out
  // of range falls back to the default. A lifetime write out of range is
  // dropped entirely and leaves the ring as it is.
  assign area_wr = cfg_data_i[AREA_W-1:0];

  always_comb begin
    area_d     = area_q;
    lifetime_d = lifetime_q;
    clear      = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_AREA_SIZE: begin
          area_d = (area_wr >= AREA_W'(1) && area_wr <= AREA_LIM) ? area_wr : AREA_INIT;
          clear  = 1'b1;
        end
        REG_ENTRY_LIFETIME: begin
          if (cfg_data_i >= LIFETIME_MIN && cfg_data_i <= LIFETIME_MAX) begin
            lifetime_d = cfg_data_i;
            clear      = 1'b1;
          end
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q     <= AREA_INIT;
      lifetime_q <= DEFAULT_LIFETIME;
    end else begin
      area_q     <= area_d;
      lifetime_q <= lifetime_d;
    end
  end

  // The clear reaches the engine in the same cycle as the write, so the
  // ring and the new settings change at the same clock edge.
  always_comb begin
    ring_cfg.area_size = area_q;
    ring_cfg.lifetime  = lifetime_q;
    ring_cfg.clear     = clear;
  end

  // Front: accepts words and queues them as commands.
  amr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: holds the ring, executes posts and scans ticks into the output
  // register; the scan waits while that register is full and the consumer stalls.
  amr_back #(
    .LIM (LIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (ring_cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
